// ===== hdl/prsw_pkg.sv =====
`default_nettype none

package prsw_pkg;

    // Default depth of the loss history.
    localparam int HISTORY_LEN_DEF = 5;

    // Register widths.
    localparam int ATTEMPTS_W = 8;
    localparam int LOSSES_W   = 3;
    localparam int LOSSES_MAX = 7;

    // Stream widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOSSES   = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [ATTEMPTS_W-1:0] MAX_ATTEMPTS_RST = 8'd20;
    localparam logic [LOSSES_W-1:0]   MAX_LOSSES_RST   = 3'd1;

    // Event kinds.
    localparam logic [1:0] REQ_SEND    = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        ACT_IGNORED   = 3'd0,
        ACT_TRANSMIT  = 3'd1,
        ACT_RETRANS   = 3'd2,
        ACT_DELIVERED = 3'd3,
        ACT_ACCEPTED  = 3'd4,
        ACT_GAVEUP    = 3'd5,
        ACT_BUSY      = 3'd6
    } action_t;

    typedef struct packed {
        logic [ATTEMPTS_W-1:0] max_attempts;
        logic [LOSSES_W-1:0]   max_losses;
    } cfg_t;

    typedef struct packed {
        logic [ATTEMPTS_W-1:0] attempts;
        logic [LOSSES_W-1:0]   losses;
        logic                  seq_bit;
        action_t               action;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/prsw_core.sv =====
`default_nettype none

module prsw_core #(
    parameter int HISTORY_LEN = prsw_pkg::HISTORY_LEN_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [1:0]        req_type,
    input  wire logic              ack_bit,
    input  wire prsw_pkg::cfg_t    cfg,
    output prsw_pkg::result_t      result
);
    import prsw_pkg::*;

    localparam int CW = $clog2(HISTORY_LEN + 1);
    localparam int LW = (CW > LOSSES_W + 1) ? CW : LOSSES_W + 1;

    logic                   expected_reg, expected_next;
    logic                   waiting_reg, waiting_next;
    logic [HISTORY_LEN-1:0] hist_reg, hist_next;
    logic [CW-1:0]          zeros_reg, zeros_next;
    logic [ATTEMPTS_W-1:0]  retry_reg, retry_next;

    logic                   do_shift;
    logic                   shift_bit;
    logic [ATTEMPTS_W:0]    retry_inc;
    logic                   force_retx;
    logic [LW-1:0]          zeros_ext;
    action_t                action;
    logic                   seq;

    assign retry_inc  = {1'b0, retry_reg} + 1'b1;
    assign force_retx = LW'(zeros_reg) > LW'(cfg.max_losses);

    always_comb begin
        expected_next = expected_reg;
        waiting_next  = waiting_reg;
        retry_next    = retry_reg;
        do_shift      = 1'b0;
        shift_bit     = 1'b0;
        action        = ACT_IGNORED;
        seq           = 1'b0;
        case (req_type)
            REQ_SEND: begin
                if (waiting_reg) begin
                    action = ACT_BUSY;
                end else begin
                    seq           = expected_reg;
                    expected_next = ~expected_reg;
                    retry_next    = '0;
                    waiting_next  = 1'b1;
                    action        = ACT_TRANSMIT;
                end
            end
            REQ_ACK: begin
                if (waiting_reg && (ack_bit == expected_reg)) begin
                    do_shift     = 1'b1;
                    shift_bit    = 1'b1;
                    waiting_next = 1'b0;
                    action       = ACT_DELIVERED;
                end
            end
            REQ_TIMEOUT: begin
                if (waiting_reg) begin
                    if (force_retx) begin
                        if (retry_inc >= {1'b0, cfg.max_attempts}) begin
                            retry_next   = retry_inc[ATTEMPTS_W] ? '1
                                                                 : retry_inc[ATTEMPTS_W-1:0];
                            do_shift     = 1'b1;
                            waiting_next = 1'b0;
                            action       = ACT_GAVEUP;
                        end else begin
                            retry_next = retry_inc[ATTEMPTS_W-1:0];
                            seq        = ~expected_reg;
                            action     = ACT_RETRANS;
                        end
                    end else begin
                        do_shift     = 1'b1;
                        waiting_next = 1'b0;
                        action       = ACT_ACCEPTED;
                    end
                end
            end
            default: begin
                action = ACT_IGNORED;
            end
        endcase
    end

    // The zero count follows the history: one bit enters, the oldest leaves.
    always_comb begin
        hist_next  = hist_reg;
        zeros_next = zeros_reg;
        if (do_shift) begin
            hist_next  = {hist_reg[HISTORY_LEN-2:0], shift_bit};
            zeros_next = zeros_reg + CW'(!shift_bit) - CW'(!hist_reg[HISTORY_LEN-1]);
        end
    end

    assign zeros_ext = LW'(zeros_next);

    always_comb begin
        result.action   = action;
        result.seq_bit  = seq;
        result.losses   = (zeros_ext > LW'(LOSSES_MAX)) ? LOSSES_W'(LOSSES_MAX)
                                                        : zeros_ext[LOSSES_W-1:0];
        result.attempts = retry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= 1'b0;
            waiting_reg  <= 1'b0;
            hist_reg     <= '1;
            zeros_reg    <= '0;
            retry_reg    <= '0;
        end else if (step) begin
            expected_reg <= expected_next;
            waiting_reg  <= waiting_next;
            hist_reg     <= hist_next;
            zeros_reg    <= zeros_next;
            retry_reg    <= retry_next;
        end
    end

    // The running zero count always matches the history it summarizes.
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(~hist_reg) == 32'(zeros_reg))
        else $error("zero count out of step with loss history");

    // A transmit leaves a segment in flight with a fresh retry count.
    a_transmit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && action == ACT_TRANSMIT) |=> (waiting_reg && retry_reg == '0))
        else $error("transmit did not start a wait");

    // The retry count only moves while a segment is outstanding or on a send.
    a_retry_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!step || (!waiting_reg && req_type != REQ_SEND)) |=> $stable(retry_reg))
        else $error("retry count changed without cause");

    // Giving up, accepting a loss or a delivery always ends the wait.
    a_end_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (action == ACT_GAVEUP || action == ACT_ACCEPTED
                  || action == ACT_DELIVERED)) |=> !waiting_reg)
        else $error("segment still in flight after it was closed");

endmodule

`default_nettype wire

// ===== hdl/prsw_outreg.sv =====
`default_nettype none

module prsw_outreg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire prsw_pkg::result_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output prsw_pkg::result_t      out_data
);
    import prsw_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A waiting result does not block the next transfer when it leaves now.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/partial_reliability_stop_and_wait_sender_top.sv =====
// A registered result shows on the master side the cycle after its input transfer.
// Throughput: one event per cycle; the link state updates in the accepting cycle.
// The only backpressure is a full result register whose result is not being taken.
// Reset (aresetn low, synchronous): idle, sequence bit 0, history all delivered,
// retry count 0, max_attempts 20, max_losses 1, no result pending.
`default_nettype none

module partial_reliability_stop_and_wait_sender_top #(
    parameter int HISTORY_LEN = prsw_pkg::HISTORY_LEN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Event stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] req_type, [2] ack_bit, [7:3] zero
    input  wire logic [prsw_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [2:0] action, [3] seq_bit, [6:4] losses, [14:7] attempts, [15] zero
    output logic [prsw_pkg::M_TDATA_W-1:0]         m_tdata,
    // Configuration writes.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [prsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [prsw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import prsw_pkg::*;

    cfg_t    cfg_reg;
    logic    step;
    result_t core_result;
    result_t out_result;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_attempts <= MAX_ATTEMPTS_RST;
            cfg_reg.max_losses   <= MAX_LOSSES_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_ATTEMPTS: cfg_reg.max_attempts <= cfg_data[ATTEMPTS_W-1:0];
                CFG_MAX_LOSSES:   cfg_reg.max_losses   <= cfg_data[LOSSES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The core advances its state on every accepted event transfer.
    assign step = s_tvalid && s_tready;

    prsw_core #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .req_type (s_tdata[1:0]),
        .ack_bit  (s_tdata[2]),
        .cfg      (cfg_reg),
        .result   (core_result)
    );

    // The result register holds one finished result until the sink takes it.
    prsw_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {1'b0, out_result.attempts, out_result.losses,
                      out_result.seq_bit, out_result.action};

endmodule

`default_nettype wire
